### design/vfuf_pkg.sv
// Package with the shared types and constants of the video frame fragmenter.
`timescale 1ns / 1ps
package vfuf_pkg;

  localparam logic [15:0] HDR_LEN     = 16'd24;
  localparam logic [15:0] MTU_FLOOR   = 16'd256;
  localparam logic [15:0] MTU_RESET   = 16'd1400;
  localparam logic [7:0]  HDR_VERSION = 8'd1;
  localparam logic [4:0]  HDR_LAST    = 5'd23;

  localparam logic [7:0] MAGIC_0 = 8'h48;  // 'H'
  localparam logic [7:0] MAGIC_1 = 8'h54;  // 'T'
  localparam logic [7:0] MAGIC_2 = 8'h56;  // 'V'
  localparam logic [7:0] MAGIC_3 = 8'h46;  // 'F'

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_HDR,
    ST_PAY
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic        rem_nz;
  } div_rsp_t;

endpackage

### design/vfuf_if.sv
// Handshake interfaces for the configuration, frame byte and packet byte channels.
`timescale 1ns / 1ps
interface vfuf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] mtu;
  modport source (output valid, output mtu, input ready);
  modport sink (input valid, input mtu, output ready);
endinterface

interface vfuf_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic [31:0] frame_bytes;
  modport source (output valid, output frame_byte, output frame_bytes, input ready);
  modport sink (input valid, input frame_byte, input frame_bytes, output ready);
endinterface

interface vfuf_packet_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_end;
  modport source (output valid, output packet_byte, output packet_end, input ready);
  modport sink (input valid, input packet_byte, input packet_end, output ready);
endinterface

### design/vfuf_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, for the fragment count.
`timescale 1ns / 1ps
module vfuf_divider
  import vfuf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic        done;

  logic [16:0] shifted;
  logic        ge;

  assign shifted = {rem, quo[31]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      // The remainder stays below the 16-bit divisor, so the low bits suffice.
      rem <= ge ? 16'(shifted - {1'b0, dsr}) : shifted[15:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;
  assign rsp.rem_nz   = rem != 16'd0;

endmodule

### design/video_frame_udp_fragmenter_core.sv
// Top level of the video frame fragmenter: sequencer, frame state and output register.
`timescale 1ns / 1ps
// The block cuts an encoded video frame into datagram fragments. Frame bytes come
// in on frame_in, one per transaction, each carrying the total frame size, which
// is read at the frame's first byte. Fragments leave on packet_out as a byte
// stream: a 24-byte big-endian header, then up to max(mtu, 256) - 24 payload
// bytes, with packet_end set on the last byte of each fragment. The cfg channel
// writes the mtu register; it is always ready, and a new value applies from the
// next frame's first byte.
// The block handles one frame byte at a time and drops frame_in.ready while it
// works on it. A plain payload byte passes from the idle state to the payload
// state. A byte that opens a later fragment passes the header state first, which
// sends the 24 header bytes. The first byte of a frame runs the serial divider
// for the fragment count: the divide and evaluate states come before its 24 header
// bytes and the payload byte. Bytes past a wrapped fragment count and bytes of a
// zero-size frame are taken with no output. A one-byte output register sits
// between the sequencer and packet_out; when the receiver stalls it holds its
// transaction and the sequencer waits. Reset (rst, synchronous) sets mtu to 1400,
// clears the frame id and all frame state and empties the output register.
module video_frame_udp_fragmenter_core
  import vfuf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  vfuf_cfg_if.sink             cfg,
  vfuf_frame_if.sink           frame_in,
  vfuf_packet_if.source        packet_out
);

  state_t state, state_next;

  logic [15:0] mtu;
  logic [31:0] frame_counter;
  logic [31:0] frame_offset;
  logic [31:0] frame_total;
  logic [15:0] fragment_index;
  logic [15:0] fragment_total;
  logic [15:0] fragment_fill;
  logic [15:0] payload_limit;

  logic [7:0]  cur_byte;
  logic [15:0] psize;
  logic        last_flag;
  logic [4:0]  hcnt;

  logic        ob_valid;
  logic [7:0]  ob_byte;
  logic        ob_end;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_acc;
  logic        ob_free;
  logic        start_byte;
  logic [15:0] mtu_eff;
  logic [15:0] limit_calc;
  logic [31:0] remaining;
  logic        silent;
  logic [15:0] psize_calc;
  logic        last_calc;
  logic        need_hdr;
  logic [31:0] offset_inc;
  logic [31:0] offset_adv;

  logic        in_ready;
  logic        div_start;
  logic        decide;
  logic        hdr_load;
  logic        pay_load;

  // Header byte at position idx of the 24-byte header, most significant first.
  function automatic logic [7:0] hdr_byte(
    input logic [4:0]  idx,
    input logic [31:0] id,
    input logic [15:0] frag_idx,
    input logic [15:0] frag_tot,
    input logic [31:0] total,
    input logic [15:0] size
  );
    logic [7:0] b;
    case (idx)
      5'd0:    b = MAGIC_0;
      5'd1:    b = MAGIC_1;
      5'd2:    b = MAGIC_2;
      5'd3:    b = MAGIC_3;
      5'd4:    b = HDR_VERSION;
      5'd5:    b = 8'd0;
      5'd6:    b = HDR_LEN[15:8];
      5'd7:    b = HDR_LEN[7:0];
      5'd8:    b = id[31:24];
      5'd9:    b = id[23:16];
      5'd10:   b = id[15:8];
      5'd11:   b = id[7:0];
      5'd12:   b = frag_idx[15:8];
      5'd13:   b = frag_idx[7:0];
      5'd14:   b = frag_tot[15:8];
      5'd15:   b = frag_tot[7:0];
      5'd16:   b = total[31:24];
      5'd17:   b = total[23:16];
      5'd18:   b = total[15:8];
      5'd19:   b = total[7:0];
      5'd20:   b = size[15:8];
      5'd21:   b = size[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  assign in_acc     = frame_in.valid && in_ready;
  assign ob_free    = !ob_valid || packet_out.ready;
  assign start_byte = frame_offset == 32'd0;

  assign mtu_eff    = (mtu < MTU_FLOOR) ? MTU_FLOOR : mtu;
  assign limit_calc = mtu_eff - HDR_LEN;

  // Per-byte decision, made from the registered frame state.
  assign remaining  = frame_total - frame_offset;
  assign silent     = fragment_index == fragment_total;
  assign psize_calc = (remaining < {16'd0, payload_limit}) ? remaining[15:0] : payload_limit;
  assign last_calc  = (({1'b0, fragment_fill} + 17'd1) >= {1'b0, payload_limit})
                      || (remaining == 32'd1);
  assign need_hdr   = fragment_fill == 16'd0;
  assign offset_inc = frame_offset + 32'd1;
  assign offset_adv = (offset_inc == frame_total) ? 32'd0 : offset_inc;

  vfuf_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = frame_in.frame_bytes;
  assign div_req.divisor  = limit_calc;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (start_byte) begin
            if (frame_in.frame_bytes != 32'd0) state_next = ST_DIV;
          end else if (!silent) begin
            state_next = need_hdr ? ST_HDR : ST_PAY;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (silent) state_next = ST_IDLE;
        else        state_next = need_hdr ? ST_HDR : ST_PAY;
      end
      ST_HDR: begin
        if (ob_free && hcnt == HDR_LAST) state_next = ST_PAY;
      end
      ST_PAY: begin
        if (ob_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == ST_IDLE;
    div_start = (state == ST_IDLE) && in_acc && start_byte
                && (frame_in.frame_bytes != 32'd0);
    decide    = ((state == ST_IDLE) && in_acc && !start_byte) || (state == ST_EVAL);
    hdr_load  = (state == ST_HDR) && ob_free;
    pay_load  = (state == ST_PAY) && ob_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mtu            <= MTU_RESET;
      frame_counter  <= '0;
      frame_offset   <= '0;
      frame_total    <= '0;
      fragment_index <= '0;
      fragment_total <= '0;
      fragment_fill  <= '0;
      payload_limit  <= '0;
    end else begin
      if (cfg.valid) mtu <= cfg.mtu;
      if (div_start) begin
        frame_total    <= frame_in.frame_bytes;
        payload_limit  <= limit_calc;
        frame_counter  <= frame_counter + 32'd1;
        fragment_index <= '0;
        fragment_fill  <= '0;
      end
      if (state == ST_DIV && div_rsp.done) begin
        fragment_total <= 16'(div_rsp.quotient[15:0] + {15'd0, div_rsp.rem_nz});
      end
      // Bytes past a wrapped fragment count only advance the offset.
      if (decide && silent) frame_offset <= offset_adv;
      if (pay_load) begin
        frame_offset <= offset_adv;
        if (last_flag) begin
          fragment_fill  <= '0;
          fragment_index <= fragment_index + 16'd1;
        end else begin
          fragment_fill <= fragment_fill + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) cur_byte <= frame_in.frame_byte;
    if (decide) begin
      psize     <= psize_calc;
      last_flag <= last_calc;
      hcnt      <= '0;
    end else if (hdr_load) begin
      hcnt <= hcnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (hdr_load || pay_load) begin
      ob_valid <= 1'b1;
    end else if (packet_out.ready) begin
      ob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_load) begin
      ob_byte <= hdr_byte(hcnt, frame_counter, fragment_index, fragment_total,
                          frame_total, psize);
      ob_end  <= 1'b0;
    end else if (pay_load) begin
      ob_byte <= cur_byte;
      ob_end  <= last_flag;
    end
  end

  assign cfg.ready              = 1'b1;
  assign frame_in.ready         = in_ready;
  assign packet_out.valid       = ob_valid;
  assign packet_out.packet_byte = ob_byte;
  assign packet_out.packet_end  = ob_end;

endmodule

### design/vfuf_checker.sv
// Port-level checker for the fragmenter output stream, bound to the top level.
`timescale 1ns / 1ps
module vfuf_checker
  import vfuf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_end
);

  logic       out_acc;
  logic       expect_magic;
  logic [4:0] frag_cnt;

  assign out_acc = out_valid && out_ready;

  // Tracks fragment boundaries: the transaction after a fragment end opens a header.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_magic <= 1'b1;
      frag_cnt     <= '0;
    end else if (out_acc) begin
      expect_magic <= out_end;
      if (out_end)                   frag_cnt <= '0;
      else if (frag_cnt <= HDR_LAST) frag_cnt <= frag_cnt + 5'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_end))
    else $error("packet output changed while stalled");

  a_magic_first: assert property (@(posedge clk) disable iff (rst)
    out_acc && expect_magic |-> out_byte == MAGIC_0)
    else $error("fragment does not open with the header magic");

  a_end_after_hdr: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_end |-> frag_cnt > HDR_LAST)
    else $error("fragment end marked inside the header");

endmodule

bind video_frame_udp_fragmenter_core vfuf_checker u_vfuf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (packet_out.valid),
  .out_ready (packet_out.ready),
  .out_byte  (packet_out.packet_byte),
  .out_end   (packet_out.packet_end)
);
